FILE: rtl/tdpt_pkg.sv
package tdpt_pkg;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_BOUND,
      ST_DIVIDE,
      ST_REMCHK
   } state_type;

   // Remainder bits resolved per divide cycle
   localparam int DIV_STEPS = 4;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // capture the incoming value
      logic init_loop;  // first odd divisor and its square
      logic start_div;  // restart the remainder unit
      logic div_step;   // one divide cycle
      logic next_d;     // advance to the next odd divisor
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic neg;        // sign bit set
      logic lt2;        // magnitude below 2
      logic lt4;        // magnitude below 4
      logic even;       // low bit clear
      logic bound_over; // divisor squared exceeds the value
      logic div_last;   // current divide cycle is the last one
      logic rem_zero;   // remainder is zero
   } sts_type;

endpackage

FILE: rtl/tdpt_dp.sv
module tdpt_dp import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_WIDTH-1:0] value,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int MAG_W   = DATA_WIDTH - 1;
   localparam int DIV_W   = DATA_WIDTH / 2 + 1;
   localparam int SQ_W    = DATA_WIDTH + 1;
   localparam int NUM_W   = ((MAG_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int DIV_CYC = NUM_W / DIV_STEPS;
   localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

   logic             neg_ff,    neg_in;
   logic [MAG_W-1:0] n_ff,      n_in;
   logic [DIV_W-1:0] d_ff,      d_in;
   logic [SQ_W-1:0]  sq_ff,     sq_in;
   logic [DIV_W-1:0] rem_ff,    rem_in;
   logic [NUM_W-1:0] num_sh_ff, num_sh_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic [DIV_W-1:0] rem_step;

   // Restoring remainder, DIV_STEPS bits per cycle
   always_comb begin
      logic [DIV_W:0]   r;
      logic [DIV_W-1:0] rv;
      rv = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r = {rv, num_sh_ff[NUM_W-1-i]};
         if (r >= {1'b0, d_ff}) begin
            r = r - {1'b0, d_ff};
         end
         rv = r[DIV_W-1:0];
      end
      rem_step = rv;
   end

   // Next values of the datapath registers
   always_comb begin
      neg_in    = neg_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      num_sh_in = num_sh_ff;
      cnt_in    = cnt_ff;
      if (cmd.load) begin
         neg_in = value[DATA_WIDTH-1];
         n_in   = value[MAG_W-1:0];
      end
      if (cmd.init_loop) begin
         d_in  = DIV_W'(3);
         sq_in = SQ_W'(9);
      end
      if (cmd.next_d) begin
         // (d+2)^2 = d^2 + 4d + 4
         d_in  = d_ff + DIV_W'(2);
         sq_in = sq_ff + (SQ_W'(d_ff) << 2) + SQ_W'(4);
      end
      if (cmd.start_div) begin
         rem_in    = '0;
         num_sh_in = NUM_W'(n_ff);
         cnt_in    = '0;
      end
      if (cmd.div_step) begin
         rem_in    = rem_step;
         num_sh_in = num_sh_ff << DIV_STEPS;
         cnt_in    = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      num_sh_ff <= num_sh_in;
      cnt_ff    <= cnt_in;
   end

   // Status back to the controller
   always_comb begin
      sts.neg        = neg_ff;
      sts.lt2        = n_ff < MAG_W'(2);
      sts.lt4        = n_ff < MAG_W'(4);
      sts.even       = ~n_ff[0];
      sts.bound_over = sq_ff > SQ_W'(n_ff);
      sts.div_last   = cnt_ff == CNT_W'(DIV_CYC - 1);
      sts.rem_zero   = rem_ff == '0;
   end

   // Remainder stays below the divisor after every divide cycle
   a_rem_lt_d: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < d_ff)
      else $error("remainder not below divisor");

   // Divisor stays odd while stepping
   a_d_odd: assert property (@(posedge clock) disable iff (reset)
      (cmd.next_d || cmd.init_loop) |=> d_ff[0])
      else $error("even divisor");

   // Each remainder pass starts from a clean remainder and count
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> (rem_ff == '0 && cnt_ff == '0))
      else $error("remainder unit not cleared");

endmodule

FILE: rtl/tdpt_ctrl.sv
module tdpt_ctrl import tdpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_prime,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      prime_ff, prime_in;
   logic      slot_free;
   logic      finish;
   logic      result;
   logic      emit;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      finish   = 1'b0;
      result   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (sts.neg || sts.lt2 || sts.lt4 || sts.even) begin
               finish = 1'b1;
               // 2 and 3 are prime; below 2 and other evens are not
               result = ~sts.neg & ~sts.lt2 & sts.lt4;
            end else begin
               cmd.init_loop = 1'b1;
               state_in      = ST_BOUND;
            end
         end
         ST_BOUND: begin
            if (sts.bound_over) begin
               finish = 1'b1;
               result = 1'b1;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_REMCHK;
            end
         end
         ST_REMCHK: begin
            if (sts.rem_zero) begin
               finish = 1'b1;
               result = 1'b0;
            end else begin
               cmd.next_d = 1'b1;
               state_in   = ST_BOUND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // hold in place until the output register can take the result
      emit = finish & slot_free;
      if (emit) begin
         state_in = ST_IDLE;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      prime_in     = prime_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         prime_in     = result;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prime_ff <= prime_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = prime_ff;

   // A finished item always returns the controller to idle
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> state_ff == ST_IDLE)
      else $error("emit did not return to idle");

   // Negative values and values below 2 never report prime
   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLASSIFY && (sts.neg || sts.lt2)) |-> !result)
      else $error("value below 2 reported prime");

   // A new beat appears only from an emitted result
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result beat without emit");

endmodule

FILE: rtl/trial_division_prime_test.sv
// Trial-division primality test.
// Input channel req_: one beat carries req_value, a signed DATA_WIDTH-bit
// integer; the beat is taken when req_valid is high and req_stall is low.
// Result channel rsp_: one beat per input with rsp_prime, 1 for a prime.
// Values below 2 (negative included) report 0; 2 and 3 report 1.
// Negative, even and below-4 values are settled in ST_CLASSIFY and written to
// the output register once it is free. Odd values walk odd divisors 3, 5, 7,
// ... while d*d <= value; for each divisor the controller passes ST_BOUND,
// then ST_DIVIDE, where the remainder unit resolves 4 quotient bits per
// cycle, then ST_REMCHK. Worst case at 32 bits is about 23170 divisors.
// One item is in work at a time: req_stall is high from acceptance until the
// result has been written to the output register. That register lets the
// next item be taken while a result waits; if rsp_stall holds a result and
// another one finishes, the controller waits before writing it.
// Reset (synchronous, active high) empties the output register and returns
// the controller to idle; no other state is kept between items.
module trial_division_prime_test import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_prime
);

   cmd_type cmd;
   sts_type sts;

   tdpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_prime (rsp_prime),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdpt_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .value (req_value),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule
